// ===== rtl/core/icr_pkg.sv =====
`default_nettype none
package icr_pkg;

   // radicand bits consumed per root bit
   localparam int GROUP_BITS = 3;

   // root bits (and pipeline stages) for a radicand word of the given width
   function automatic int root_bits(input int word_bits);
      return (word_bits + GROUP_BITS - 1) / GROUP_BITS;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/integer_cube_root_unit.sv =====
// integer cube root, floor(cbrt(radicand)), one root bit per pipeline stage
// throughput: one item per cycle while rsp_stall is low, set by the fully pipelined stage chain
// a stalled output holds its item; stages behind it keep filling empty slots
// reset (synchronous, active high) clears the stage valid bits only
`default_nettype none
module integer_cube_root_unit #(
   parameter int WORD_BITS = 64,
   localparam int ROOT_BITS = icr_pkg::root_bits(WORD_BITS)
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire  [WORD_BITS-1:0] req_radicand,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic [ROOT_BITS-1:0] rsp_root
);

   localparam int A_BITS = 2 * ROOT_BITS + 2;
   localparam int B_BITS = ROOT_BITS + 2;

   logic                 valid_w [0:ROOT_BITS];
   logic                 stall_w [0:ROOT_BITS];
   logic [WORD_BITS-1:0] rem_w   [0:ROOT_BITS];
   logic [A_BITS-1:0]    a_w     [0:ROOT_BITS];
   logic [B_BITS-1:0]    b_w     [0:ROOT_BITS];
   logic [ROOT_BITS-1:0] r_w     [0:ROOT_BITS];

   assign valid_w[0] = req_valid;
   assign rem_w[0]   = req_radicand;
   assign a_w[0]     = '0;
   assign b_w[0]     = '0;
   assign r_w[0]     = '0;
   assign req_stall  = stall_w[0];

   genvar k;
   generate
      for (k = 0; k < ROOT_BITS; k++) begin : g_stage
         icr_stage #(
            .WORD_BITS(WORD_BITS),
            .GROUP(ROOT_BITS - 1 - k)
         ) u_stage (
            .clock(clock),
            .reset(reset),
            .in_valid(valid_w[k]),
            .in_stall(stall_w[k]),
            .in_rem(rem_w[k]),
            .in_a(a_w[k]),
            .in_b(b_w[k]),
            .in_r(r_w[k]),
            .out_valid(valid_w[k+1]),
            .out_stall(stall_w[k+1]),
            .out_rem(rem_w[k+1]),
            .out_a(a_w[k+1]),
            .out_b(b_w[k+1]),
            .out_r(r_w[k+1])
         );
      end
   endgenerate

   assign stall_w[ROOT_BITS] = rsp_stall;
   assign rsp_valid          = valid_w[ROOT_BITS];
   assign rsp_root           = r_w[ROOT_BITS];

endmodule
`default_nettype wire

// ===== rtl/core/icr_stage.sv =====
`default_nettype none
module icr_stage #(
   parameter int WORD_BITS = 64,
   parameter int GROUP = 0
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  in_valid,
   output logic                                 in_stall,
   input  wire  [WORD_BITS-1:0]                 in_rem,
   input  wire  [2*icr_pkg::root_bits(WORD_BITS)+1:0] in_a,
   input  wire  [icr_pkg::root_bits(WORD_BITS)+1:0]   in_b,
   input  wire  [icr_pkg::root_bits(WORD_BITS)-1:0]   in_r,
   output logic                                 out_valid,
   input  wire                                  out_stall,
   output logic [WORD_BITS-1:0]                 out_rem,
   output logic [2*icr_pkg::root_bits(WORD_BITS)+1:0] out_a,
   output logic [icr_pkg::root_bits(WORD_BITS)+1:0]   out_b,
   output logic [icr_pkg::root_bits(WORD_BITS)-1:0]   out_r
);

   localparam int ROOT_BITS = icr_pkg::root_bits(WORD_BITS);
   localparam int A_BITS    = 2 * ROOT_BITS + 2;
   localparam int B_BITS    = ROOT_BITS + 2;
   localparam int S         = icr_pkg::GROUP_BITS * GROUP;
   localparam int X_BITS    = ((WORD_BITS > A_BITS + 2) ? WORD_BITS : A_BITS + 2) + 1;
   localparam logic [WORD_BITS-1:0] LOW_MASK = ~({WORD_BITS{1'b1}} << S);

   logic [X_BITS-1:0]    rem_hi;
   logic [X_BITS-1:0]    trial;
   logic [X_BITS-1:0]    diff;
   logic                 accept;
   logic                 load;
   logic [A_BITS-1:0]    a4;
   logic [A_BITS-1:0]    a_grow;
   logic [WORD_BITS-1:0] rem_in;
   logic [A_BITS-1:0]    a_in;
   logic [B_BITS-1:0]    b_in;
   logic [ROOT_BITS-1:0] r_in;
   logic                 valid_ff;
   logic [WORD_BITS-1:0] rem_ff;
   logic [A_BITS-1:0]    a_ff;
   logic [B_BITS-1:0]    b_ff;
   logic [ROOT_BITS-1:0] r_ff;

   // trial term 3d(d+1)+1 with d = 2r, from a = 3r*r and b = 3r
   always_comb begin
      rem_hi = X_BITS'(in_rem >> S);
      trial  = (X_BITS'(in_a) << 2) + (X_BITS'(in_b) << 1) + X_BITS'(1);
      diff   = rem_hi - trial;
      accept = ~diff[X_BITS-1];
      a4     = in_a << 2;
      a_grow = a4 + (A_BITS'(in_b) << 2) + A_BITS'(3);
      if (accept) begin
         rem_in = (in_rem & LOW_MASK) | (WORD_BITS'(diff) << S);
         a_in   = a_grow;
         b_in   = (in_b << 1) + B_BITS'(3);
      end else begin
         rem_in = in_rem;
         a_in   = a4;
         b_in   = in_b << 1;
      end
      r_in = {in_r[ROOT_BITS-2:0], accept};
   end

   assign in_stall = valid_ff & out_stall;
   assign load     = in_valid & ~in_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= rem_in;
         a_ff   <= a_in;
         b_ff   <= b_in;
         r_ff   <= r_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_r     = r_ff;

endmodule
`default_nettype wire
